/* rtl/zobrist_position_hasher_defines.svh */
// Assertion macros for the Zobrist position hasher.
// Included by the top level; no other dependencies.
`ifndef ZOBRIST_POSITION_HASHER_DEFINES_SVH
`define ZOBRIST_POSITION_HASHER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ZPH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("zph assertion failed");
`define ZPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("zph assertion failed");
`else
`define ZPH_ASSERT(lbl, clk, rstn, prop)
`define ZPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/zph_pkg.sv */
// Constants shared by the Zobrist position hasher: board geometry,
// splitmix64 constants and operation codes. No dependencies.
`default_nettype none

package zph_pkg;

  localparam int unsigned BOARD_SIDE = 15;
  localparam int unsigned ENTRIES    = BOARD_SIDE * BOARD_SIDE * 2;
  localparam int unsigned ADDR_W     = $clog2(ENTRIES);
  localparam int unsigned COORD_W    = 4;
  localparam int unsigned OP_W       = 2;

  localparam logic [63:0] GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MUL1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MUL2  = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] SEED  = 64'h243F_6A88_85A3_08D3;

  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;

  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

endpackage

`default_nettype wire

/* rtl/zobrist_position_hasher.sv */
// Zobrist position hasher: splitmix64 key table fill sequencer, key table
// memory and running key update pipeline.
// Depends on zph_pkg and zobrist_position_hasher_defines.svh.
//
// Usage:
//   Slave stream carries one command per transaction: tuser selects toggle,
//   clear or load; tdata carries the coordinates, stone colour and load key.
//   Master stream returns the running key after each command, with tuser
//   flagging a toggle rejected for out-of-range coordinates.
//   After reset the sequencer fills the 450-entry key table one entry at a
//   time through a shared 32x32 multiplier; s_axis_tready_o stays low until
//   the fill is done.
//   The table is read at the accepting edge into the read stage; the key
//   update writes the output register when the read stage advances.
//   Throughput: one command per cycle unless the receiver stalls; the table
//   read port and the running key register each handle one command per cycle.
//   When the receiver stalls, the output register and the read stage hold
//   and tready stays low while the read stage holds a command.
`default_nettype none
`include "zobrist_position_hasher_defines.svh"

module zobrist_position_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [3:0] x_coord, [7:4] y_coord, [8] stone, [72:9] key_value, [79:73] zero
  input  wire logic [79:0] s_axis_tdata_i,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [63:0] key
  output logic [63:0]      m_axis_tdata_o,
  // [0] rejected
  output logic [0:0]       m_axis_tuser_o
);

  localparam int unsigned AW = zph_pkg::ADDR_W;
  localparam int unsigned CW = zph_pkg::COORD_W;

  localparam logic [3:0] PH_MIX = 4'd0;
  localparam logic [3:0] PH_LL1 = 4'd1;
  localparam logic [3:0] PH_LH1 = 4'd2;
  localparam logic [3:0] PH_HL1 = 4'd3;
  localparam logic [3:0] PH_X1  = 4'd4;
  localparam logic [3:0] PH_LL2 = 4'd5;
  localparam logic [3:0] PH_LH2 = 4'd6;
  localparam logic [3:0] PH_HL2 = 4'd7;
  localparam logic [3:0] PH_WR  = 4'd8;

  logic [63:0] key_mem [zph_pkg::ENTRIES];

  // fill sequencer
  logic [3:0]    phase_q, phase_d;
  logic [AW-1:0] fill_addr_q;
  logic          fill_done_q;
  logic [63:0]   gen_q, gen_d;
  logic [63:0]   z_q, z_d;
  logic [63:0]   acc_q, acc_d;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [63:0]   gen_step;
  logic [63:0]   fill_word;
  logic          mem_we;

  // command pipeline
  localparam int unsigned OP_W_L = zph_pkg::OP_W;
  logic [OP_W_L-1:0] st1_op_q;
  logic          st1_v_q;
  logic          st1_rej_q;
  logic [63:0]   st1_kv_q;
  logic [63:0]   rd_q;
  logic [63:0]   run_key_q;
  logic [63:0]   new_key;
  logic          out_v_q;
  logic [63:0]   out_key_q;
  logic          out_rej_q;
  logic          st1_adv;
  logic          in_acc;

  logic [CW-1:0] in_x, in_y;
  logic          in_stone;
  logic [63:0]   in_kv;
  logic          in_oob;
  logic          in_rej;
  logic [AW-1:0] rd_addr;

  assign gen_step  = gen_q + zph_pkg::GAMMA;
  assign fill_word = acc_q ^ (acc_q >> zph_pkg::SHIFT_C);
  assign prod      = 64'(mul_a) * 64'(mul_b);
  assign mem_we    = !fill_done_q && (phase_q == PH_WR);

  always_comb begin
    mul_a = z_q[31:0];
    mul_b = zph_pkg::MUL1[31:0];
    case (phase_q)
      PH_LL1: mul_b = zph_pkg::MUL1[31:0];
      PH_LH1: mul_b = zph_pkg::MUL1[63:32];
      PH_HL1: begin
        mul_a = z_q[63:32];
        mul_b = zph_pkg::MUL1[31:0];
      end
      PH_LL2: mul_b = zph_pkg::MUL2[31:0];
      PH_LH2: mul_b = zph_pkg::MUL2[63:32];
      PH_HL2: begin
        mul_a = z_q[63:32];
        mul_b = zph_pkg::MUL2[31:0];
      end
      default: mul_b = zph_pkg::MUL1[31:0];
    endcase
  end

  always_comb begin
    phase_d = phase_q + 4'd1;
    gen_d   = gen_q;
    z_d     = z_q;
    acc_d   = acc_q;
    case (phase_q)
      PH_MIX: begin
        gen_d = gen_step;
        z_d   = gen_step ^ (gen_step >> zph_pkg::SHIFT_A);
      end
      PH_LL1, PH_LL2: acc_d = prod;
      PH_LH1, PH_HL1, PH_LH2, PH_HL2: acc_d = acc_q + {prod[31:0], 32'd0};
      PH_X1: z_d = acc_q ^ (acc_q >> zph_pkg::SHIFT_B);
      PH_WR: phase_d = PH_MIX;
      default: phase_d = PH_MIX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MIX;
      fill_addr_q <= '0;
      fill_done_q <= 1'b0;
      gen_q       <= zph_pkg::SEED;
    end else if (!fill_done_q) begin
      phase_q <= phase_d;
      gen_q   <= gen_d;
      if (phase_q == PH_WR) begin
        if (fill_addr_q == AW'(zph_pkg::ENTRIES - 1)) begin
          fill_done_q <= 1'b1;
        end else begin
          fill_addr_q <= fill_addr_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    z_q   <= z_d;
    acc_q <= acc_d;
  end

  // command decode
  assign in_x     = s_axis_tdata_i[3:0];
  assign in_y     = s_axis_tdata_i[7:4];
  assign in_stone = s_axis_tdata_i[8];
  assign in_kv    = s_axis_tdata_i[72:9];
  assign in_oob   = (32'(in_x) >= zph_pkg::BOARD_SIDE) ||
                    (32'(in_y) >= zph_pkg::BOARD_SIDE);
  assign in_rej   = (s_axis_tuser_i == zph_pkg::OP_TOGGLE) && in_oob;
  assign rd_addr  = in_oob ? '0 :
                    AW'((32'(in_y) * zph_pkg::BOARD_SIDE + 32'(in_x)) * 2 + 32'(in_stone));

  assign st1_adv         = st1_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = fill_done_q && (!st1_v_q || st1_adv);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[fill_addr_q] <= fill_word;
    end
    if (in_acc) begin
      rd_q <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st1_op_q  <= s_axis_tuser_i;
      st1_rej_q <= in_rej;
      st1_kv_q  <= in_kv;
    end
    if (st1_adv) begin
      out_key_q <= new_key;
      out_rej_q <= st1_rej_q;
    end
  end

  always_comb begin
    case (st1_op_q)
      zph_pkg::OP_TOGGLE: new_key = st1_rej_q ? run_key_q : (run_key_q ^ rd_q);
      zph_pkg::OP_CLEAR:  new_key = '0;
      zph_pkg::OP_LOAD:   new_key = st1_kv_q;
      default:            new_key = run_key_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_v_q   <= 1'b0;
      out_v_q   <= 1'b0;
      run_key_q <= '0;
    end else begin
      if (in_acc) begin
        st1_v_q <= 1'b1;
      end else if (st1_adv) begin
        st1_v_q <= 1'b0;
      end
      if (st1_adv) begin
        out_v_q   <= 1'b1;
        run_key_q <= new_key;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_key_q;
  assign m_axis_tuser_o  = out_rej_q;

  `ZPH_ASSERT(a_no_cmd_during_fill, clk_i, rst_ni, !fill_done_q |-> (!st1_v_q && !out_v_q))
  `ZPH_ASSERT_NEXT(a_read_holds, clk_i, rst_ni, st1_v_q && !st1_adv, $stable(rd_q) && st1_v_q)
  `ZPH_ASSERT_NEXT(a_reject_keeps_key, clk_i, rst_ni, st1_adv && st1_rej_q, out_key_q == $past(run_key_q))
  `ZPH_ASSERT(a_phase_range, clk_i, rst_ni, phase_q <= PH_WR)

endmodule

`default_nettype wire

/* tb/tb_zobrist_position_hasher.sv */
// Self-checking testbench for zobrist_position_hasher: streams toggle, clear,
// load and unused commands under varied flow control and checks every key.
// Depends on zph_pkg and the RTL of the hasher.
`timescale 1ns / 1ps

module tb_zobrist_position_hasher;

  localparam logic [zph_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [zph_pkg::OP_W-1:0]    op;
    logic [zph_pkg::COORD_W-1:0] x;
    logic [zph_pkg::COORD_W-1:0] y;
    logic                        stone;
    logic [63:0]                 key_in;
    int                          tx_idle;
    int                          rx_stall;
    bit                          drain;
  } hash_cmd_t;

  typedef struct {
    logic [63:0] key;
    logic        rejected;
  } key_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_axis_tready_o;
  logic [79:0] s_data;
  logic [1:0]  s_user;
  logic        m_axis_tvalid_o;
  logic        m_ready;
  logic [63:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  logic [63:0] zobrist_keys [zph_pkg::ENTRIES];
  logic [63:0] position_key;
  hash_cmd_t   pending_cmds [$];
  key_result_t expected_keys [$];
  hash_cmd_t   in_flight;
  key_result_t want;
  bit          take;
  int          rx_stall_pct;
  int          error_count;
  int          cmds_sent;
  int          keys_checked;
  int          rejects_seen;

  zobrist_position_hasher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic key_result_t apply_command(input hash_cmd_t c);
    key_result_t r;
    int unsigned idx;
    r.rejected = 1'b0;
    case (c.op)
      zph_pkg::OP_TOGGLE: begin
        if (c.x >= zph_pkg::BOARD_SIDE || c.y >= zph_pkg::BOARD_SIDE) begin
          r.rejected = 1'b1;
        end else begin
          idx = (c.y * zph_pkg::BOARD_SIDE + c.x) * 2 + c.stone;
          position_key = position_key ^ zobrist_keys[idx];
        end
      end
      zph_pkg::OP_CLEAR: position_key = '0;
      zph_pkg::OP_LOAD:  position_key = c.key_in;
      default: ;
    endcase
    r.key = position_key;
    return r;
  endfunction

  task automatic push_cmd(input logic [zph_pkg::OP_W-1:0] op, input int x, input int y,
                          input logic stone, input logic [63:0] key_in,
                          input int tx_idle, input int rx_stall, input bit drain);
    hash_cmd_t c;
    c.op       = op;
    c.x        = x[zph_pkg::COORD_W-1:0];
    c.y        = y[zph_pkg::COORD_W-1:0];
    c.stone    = stone;
    c.key_in   = key_in;
    c.tx_idle  = tx_idle;
    c.rx_stall = rx_stall;
    c.drain    = drain;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly games: a clear or load, then moves on random cells with occasional
  // take-backs and off-board toggles; the remainder is unconstrained noise.
  task automatic add_random_phase(input int tx_idle, input int rx_stall, input int count);
    int n;
    int moves;
    int pick;
    int cx [$];
    int cy [$];
    int cs [$];
    bit first;
    n = 0;
    first = 1'b1;
    while (n < count) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(3) == 0) begin
          push_cmd(zph_pkg::OP_LOAD, $urandom_range(15), $urandom_range(15),
                   1'($urandom_range(1)), rand_key(), tx_idle, rx_stall, first);
        end else begin
          push_cmd(zph_pkg::OP_CLEAR, $urandom_range(15), $urandom_range(15),
                   1'($urandom_range(1)), rand_key(), tx_idle, rx_stall, first);
        end
        first = 1'b0;
        n++;
        cx.delete();
        cy.delete();
        cs.delete();
        moves = $urandom_range(5, 30);
        repeat (moves) begin
          if (cx.size() > 0 && $urandom_range(99) < 15) begin
            pick = $urandom_range(cx.size() - 1);
            push_cmd(zph_pkg::OP_TOGGLE, cx[pick], cy[pick], cs[pick][0], rand_key(),
                     tx_idle, rx_stall, 1'b0);
          end else if ($urandom_range(99) < 5) begin
            push_cmd(zph_pkg::OP_TOGGLE, $urandom_range(zph_pkg::BOARD_SIDE, 15),
                     $urandom_range(15), 1'($urandom_range(1)), rand_key(),
                     tx_idle, rx_stall, 1'b0);
          end else begin
            cx.push_back($urandom_range(zph_pkg::BOARD_SIDE - 1));
            cy.push_back($urandom_range(zph_pkg::BOARD_SIDE - 1));
            cs.push_back($urandom_range(1));
            push_cmd(zph_pkg::OP_TOGGLE, cx[$], cy[$], cs[$][0], rand_key(),
                     tx_idle, rx_stall, 1'b0);
          end
          n++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_cmd(2'($urandom_range(3)), $urandom_range(15), $urandom_range(15),
                   1'($urandom_range(1)), rand_key(), tx_idle, rx_stall, first);
          first = 1'b0;
          n++;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid      <= 1'b0;
      s_data       <= '0;
      s_user       <= '0;
      rx_stall_pct <= 0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        expected_keys.push_back(apply_command(in_flight));
        cmds_sent++;
      end
      if (!s_valid || s_axis_tready_o) begin
        take = 1'b0;
        if (pending_cmds.size() > 0) begin
          if (pending_cmds[0].drain && expected_keys.size() == 0) begin
            pending_cmds[0].drain = 1'b0;
          end
          take = !pending_cmds[0].drain && ($urandom_range(99) >= pending_cmds[0].tx_idle);
        end
        if (take) begin
          in_flight = pending_cmds.pop_front();
          s_data       <= {7'd0, in_flight.key_in, in_flight.stone, in_flight.y, in_flight.x};
          s_user       <= in_flight.op;
          rx_stall_pct <= in_flight.rx_stall;
        end
        s_valid <= take;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        if (expected_keys.size() == 0) begin
          report_mismatch($sformatf("key %h with no command outstanding", m_axis_tdata_o));
        end else begin
          want = expected_keys.pop_front();
          if (m_axis_tdata_o !== want.key) begin
            report_mismatch($sformatf("key %h, predicted %h", m_axis_tdata_o, want.key));
          end
          if (m_axis_tuser_o[0] !== want.rejected) begin
            report_mismatch($sformatf("rejected %b, predicted %b",
                                      m_axis_tuser_o[0], want.rejected));
          end
          keys_checked++;
          if (want.rejected) rejects_seen++;
        end
      end
      m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("[%0t] timeout", $realtime);
    $display("zobrist_position_hasher: mismatch");
    $finish;
  end

  initial begin
    logic [63:0] gen_state;
    logic [63:0] z;
    rst_ni       = 1'b0;
    position_key = '0;
    error_count  = 0;
    cmds_sent    = 0;
    keys_checked = 0;
    rejects_seen = 0;

    gen_state = zph_pkg::SEED;
    for (int n = 0; n < zph_pkg::ENTRIES; n++) begin
      gen_state = gen_state + zph_pkg::GAMMA;
      z = gen_state;
      z = (z ^ (z >> zph_pkg::SHIFT_A)) * zph_pkg::MUL1;
      z = (z ^ (z >> zph_pkg::SHIFT_B)) * zph_pkg::MUL2;
      zobrist_keys[n] = z ^ (z >> zph_pkg::SHIFT_C);
    end

    // corners, both colours, off-board, take-back, clears, loads and the unused code
    push_cmd(zph_pkg::OP_TOGGLE, 0, 0, 1'b0, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 0, 0, 1'b1, '1, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 14, 14, 1'b1, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 14, 14, 1'b0, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 14, 0, 1'b1, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 0, 14, 1'b0, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 15, 0, 1'b0, '1, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 0, 15, 1'b1, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 15, 15, 1'b1, '1, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 7, 7, 1'b0, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 7, 7, 1'b0, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_CLEAR, 15, 15, 1'b1, '1, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_LOAD, 0, 0, 1'b0, '1, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 8, 10, 1'b1, '0, 0, 0, 1'b0);
    push_cmd(OP_UNUSED, 15, 15, 1'b1, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_LOAD, 15, 15, 1'b1, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_LOAD, 3, 9, 1'b0, 64'hA5A5_5A5A_F0F0_0F0F, 0, 0, 1'b0);
    push_cmd(OP_UNUSED, 0, 0, 1'b0, '1, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_LOAD, 0, 0, 1'b0, rand_key(), 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_CLEAR, 0, 0, 1'b0, '0, 0, 0, 1'b0);
    push_cmd(zph_pkg::OP_TOGGLE, 12, 5, 1'b1, '0, 0, 0, 1'b0);

    add_random_phase(0, 0, 325);
    add_random_phase(63, 0, 325);
    add_random_phase(0, 63, 325);
    add_random_phase(24, 24, 325);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() > 0 || s_valid || expected_keys.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);

    $display("Sent %0d commands across four flow-control phases; checked %0d keys,",
             cmds_sent, keys_checked);
    $display("%0d of them off-board toggles; %0d mismatches.", rejects_seen, error_count);
    if (error_count == 0) begin
      $display("zobrist_position_hasher: match");
    end else begin
      $display("zobrist_position_hasher: mismatch");
    end
    $finish;
  end

endmodule
